>>> sv/nlej_pkg.sv
// ----------------------------------------------------------------------------
// nlej_pkg
// Shared types, codes and widths of the nested-loop equi-join block.
// ----------------------------------------------------------------------------
package nlej_pkg;

  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned LEFT_POS_W  = 16;
  localparam int unsigned RIGHT_POS_W = 6;

  localparam int unsigned RIGHT_DEPTH_DEF     = 64;
  localparam int unsigned LEFT_INDEX_BITS_DEF = 16;

  // Input opcodes
  localparam logic [OPCODE_W-1:0] OP_STORE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PROBE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_PROBE,
    CMD_CLEAR
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic signed [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic [LEFT_POS_W-1:0]   left_position;
    logic [RIGHT_POS_W-1:0]  right_position;
    logic signed [KEY_W-1:0] match_key;
    logic                    last_match;
    logic                    overflow;
  } result_t;

endpackage

>>> sv/nlej_front.sv
// ----------------------------------------------------------------------------
// nlej_front
// Input side: accepts items, decodes the opcode and queues commands
// (two entries) for the execution side. Unused opcodes are dropped here.
// ----------------------------------------------------------------------------
module nlej_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic [nlej_pkg::OPCODE_W-1:0]        opcode_i,
  input  logic signed [nlej_pkg::KEY_W-1:0]    key_i,
  output logic                                 cmd_vld_o,
  output nlej_pkg::cmd_t                       cmd_o,
  input  logic                                 cmd_rdy_i
);

  nlej_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;

  logic           accept;
  logic           enq;
  logic           deq;
  nlej_pkg::cmd_t cmd_new;

  assign full   = (cnt_q == 2'd2);
  assign accept = push && !full;

  // Classify the opcode; anything unused is taken and dropped.
  always_comb begin
    cmd_new.key = key_i;
    cmd_new.cmd = nlej_pkg::CMD_STORE;
    enq         = 1'b0;
    case (opcode_i)
      nlej_pkg::OP_STORE: begin
        cmd_new.cmd = nlej_pkg::CMD_STORE;
        enq         = accept;
      end
      nlej_pkg::OP_PROBE: begin
        cmd_new.cmd = nlej_pkg::CMD_PROBE;
        enq         = accept;
      end
      nlej_pkg::OP_CLEAR: begin
        cmd_new.cmd = nlej_pkg::CMD_CLEAR;
        enq         = accept;
      end
      default: begin
        enq = 1'b0;
      end
    endcase
  end

  assign cmd_vld_o = (cnt_q != 2'd0);
  assign cmd_o     = mem_q[rd_ptr_q];
  assign deq       = cmd_vld_o && cmd_rdy_i;

  always_comb begin
    wr_ptr_d = enq ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = deq ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, enq} - {1'b0, deq};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

>>> sv/nlej_back.sv
// ----------------------------------------------------------------------------
// nlej_back
// Execution side: right-key table, counters, one-comparator scan engine and
// a two-entry result queue.
// ----------------------------------------------------------------------------
module nlej_back #(
  parameter int unsigned RIGHT_DEPTH     = nlej_pkg::RIGHT_DEPTH_DEF,
  parameter int unsigned LEFT_INDEX_BITS = nlej_pkg::LEFT_INDEX_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cmd_vld_i,
  input  nlej_pkg::cmd_t                       cmd_i,
  output logic                                 cmd_rdy_o,
  output logic                                 empty,
  input  logic                                 pop,
  output nlej_pkg::result_t                    res_o
);

  localparam int unsigned CNT_W = $clog2(RIGHT_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(RIGHT_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RIGHT_DEPTH);

  nlej_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [LEFT_INDEX_BITS-1:0] lctr_q, lctr_d;
  logic                       flag_q, flag_d;
  logic [CNT_W-1:0]           addr_q, addr_d;
  logic                       cmp_vld_q, cmp_vld_d;
  logic                       pend_vld_q, pend_vld_d;

  logic signed [nlej_pkg::KEY_W-1:0] mem_q [RIGHT_DEPTH];
  logic signed [nlej_pkg::KEY_W-1:0] rd_q;
  logic signed [nlej_pkg::KEY_W-1:0] key_q, key_d;
  logic [nlej_pkg::LEFT_POS_W-1:0]   lpos_q, lpos_d;
  logic [IDX_W-1:0]                  cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]                  pend_idx_q, pend_idx_d;

  logic        wr_en;
  logic        rd_en;
  logic [31:0] lctr_ext;
  logic        cmd_take;
  logic        issue;
  logic        match;
  logic        done;
  logic        emit;
  logic        out_full;
  logic        stall;
  logic        push_out;
  nlej_pkg::result_t res_new;

  nlej_pkg::result_t out_mem_q [2];
  logic              out_wr_q, out_rd_q;
  logic [1:0]        out_cnt_q;
  logic              pop_out;

  assign lctr_ext  = 32'(lctr_q);
  assign cmd_rdy_o = (state_q == nlej_pkg::ST_IDLE);
  assign cmd_take  = cmd_vld_i && cmd_rdy_o;

  assign issue    = (state_q == nlej_pkg::ST_SCAN) && (addr_q < cnt_q);
  assign match    = cmp_vld_q && (rd_q == key_q);
  assign done     = (state_q == nlej_pkg::ST_SCAN) && !cmp_vld_q && !issue;
  // A pending match goes out once a later match or the end of scan shows
  // whether it is the final one.
  assign emit     = pend_vld_q && (match || done);
  assign out_full = (out_cnt_q == 2'd2);
  assign stall    = emit && out_full;
  assign push_out = emit && !out_full;

  always_comb begin
    res_new.left_position  = lpos_q;
    res_new.right_position = nlej_pkg::RIGHT_POS_W'(pend_idx_q);
    res_new.match_key      = key_q;
    res_new.last_match     = done;
    res_new.overflow       = flag_q;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    lctr_d     = lctr_q;
    flag_d     = flag_q;
    addr_d     = addr_q;
    cmp_vld_d  = cmp_vld_q;
    pend_vld_d = pend_vld_q;
    key_d      = key_q;
    lpos_d     = lpos_q;
    cmp_idx_d  = cmp_idx_q;
    pend_idx_d = pend_idx_q;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    case (state_q)
      nlej_pkg::ST_IDLE: begin
        if (cmd_take) begin
          case (cmd_i.cmd)
            nlej_pkg::CMD_STORE: begin
              if (cnt_q < DEPTH_CNT) begin
                wr_en = 1'b1;
                cnt_d = cnt_q + CNT_W'(1);
              end else begin
                flag_d = 1'b1;
              end
            end
            nlej_pkg::CMD_PROBE: begin
              key_d      = cmd_i.key;
              lpos_d     = lctr_ext[nlej_pkg::LEFT_POS_W-1:0];
              lctr_d     = lctr_q + LEFT_INDEX_BITS'(1);
              addr_d     = '0;
              cmp_vld_d  = 1'b0;
              pend_vld_d = 1'b0;
              state_d    = nlej_pkg::ST_SCAN;
            end
            nlej_pkg::CMD_CLEAR: begin
              cnt_d  = '0;
              lctr_d = '0;
              flag_d = 1'b0;
            end
            default: begin
              cnt_d = cnt_q;
            end
          endcase
        end
      end
      nlej_pkg::ST_SCAN: begin
        // Hold the whole scan pipe while a result waits for queue space.
        if (!stall) begin
          rd_en     = issue;
          cmp_vld_d = issue;
          cmp_idx_d = addr_q[IDX_W-1:0];
          if (issue) begin
            addr_d = addr_q + CNT_W'(1);
          end
          if (match) begin
            pend_vld_d = 1'b1;
            pend_idx_d = cmp_idx_q;
          end else if (done) begin
            pend_vld_d = 1'b0;
            state_d    = nlej_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = nlej_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= nlej_pkg::ST_IDLE;
      cnt_q      <= '0;
      lctr_q     <= '0;
      flag_q     <= 1'b0;
      addr_q     <= '0;
      cmp_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      lctr_q     <= lctr_d;
      flag_q     <= flag_d;
      addr_q     <= addr_d;
      cmp_vld_q  <= cmp_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    lpos_q     <= lpos_d;
    cmp_idx_q  <= cmp_idx_d;
    pend_idx_q <= pend_idx_d;
  end

  // Right-key table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[IDX_W-1:0]] <= cmd_i.key;
    end
    if (rd_en) begin
      rd_q <= mem_q[addr_q[IDX_W-1:0]];
    end
  end

  // Result queue
  assign empty   = (out_cnt_q == 2'd0);
  assign pop_out = pop && !empty;
  assign res_o   = out_mem_q[out_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= 1'b0;
      out_rd_q  <= 1'b0;
      out_cnt_q <= 2'd0;
    end else begin
      if (push_out) begin
        out_wr_q <= ~out_wr_q;
      end
      if (pop_out) begin
        out_rd_q <= ~out_rd_q;
      end
      out_cnt_q <= out_cnt_q + {1'b0, push_out} - {1'b0, pop_out};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_out) begin
      out_mem_q[out_wr_q] <= res_new;
    end
  end

  a_out_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q <= 2'd2)
    else $error("result queue count out of range");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nlej_pkg::ST_IDLE) |-> (!cmp_vld_q && !pend_vld_q))
    else $error("scan pipe busy while idle");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_CNT)
    else $error("right count beyond depth");

  a_scan_cnt_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nlej_pkg::ST_SCAN) |=> $stable(cnt_q))
    else $error("table size changed during scan");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> ($stable(addr_q) && $stable(pend_vld_q)))
    else $error("scan advanced while result queue full");

endmodule

>>> sv/nested_loop_equi_join.sv
// ----------------------------------------------------------------------------
// nested_loop_equi_join
// Equi-join of streamed left keys against a stored table of right keys.
// Input (push/full): opcode_i stores key_i in the right table, probes the
// table with key_i, or clears it (table, left index, overflow flag); opcode 3
// is taken and ignored. A store into a full table is dropped and sets the
// overflow flag carried on later results.
// Results (empty/pop): one transfer per matching right entry, ascending, with
// last_match_o on the final one of a probe; a probe with no match gives none.
// Flow: a transfer is registered in the command queue before it reaches the
// execution side. Store and clear retire there as soon as they are taken; a
// probe walks the N stored keys with the single comparator, one entry per
// cycle while no result waits for queue space. A match waits until the next
// match or the scan end fixes its last mark.
// Reset clears counters, flag and both queues; table contents stay but are
// never read beyond the stored count. When the receiver stalls, hold the scan
// once the two-entry result queue is full; the two-entry command queue takes
// two more commands, then full rises.
// ----------------------------------------------------------------------------
module nested_loop_equi_join #(
  parameter int unsigned RIGHT_DEPTH     = nlej_pkg::RIGHT_DEPTH_DEF,
  parameter int unsigned LEFT_INDEX_BITS = nlej_pkg::LEFT_INDEX_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic [nlej_pkg::OPCODE_W-1:0]         opcode_i,
  input  logic signed [nlej_pkg::KEY_W-1:0]     key_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [nlej_pkg::LEFT_POS_W-1:0]       left_position_o,
  output logic [nlej_pkg::RIGHT_POS_W-1:0]      right_position_o,
  output logic signed [nlej_pkg::KEY_W-1:0]     match_key_o,
  output logic                                  last_match_o,
  output logic                                  overflow_o
);

  logic              cmd_vld;
  logic              cmd_rdy;
  nlej_pkg::cmd_t    cmd;
  nlej_pkg::result_t res;

  // Front: accept and decode, queue commands for the execution side.
  nlej_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .opcode_i  (opcode_i),
    .key_i     (key_i),
    .cmd_vld_o (cmd_vld),
    .cmd_o     (cmd),
    .cmd_rdy_i (cmd_rdy)
  );

  // Back: table updates, probe scan and result queue.
  nlej_back #(
    .RIGHT_DEPTH     (RIGHT_DEPTH),
    .LEFT_INDEX_BITS (LEFT_INDEX_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_vld_i (cmd_vld),
    .cmd_i     (cmd),
    .cmd_rdy_o (cmd_rdy),
    .empty     (empty),
    .pop       (pop),
    .res_o     (res)
  );

  // Unpack the result head onto the field ports.
  assign left_position_o  = res.left_position;
  assign right_position_o = res.right_position;
  assign match_key_o      = res.match_key;
  assign last_match_o     = res.last_match;
  assign overflow_o       = res.overflow;

endmodule
